/* design/max_priority_queue_sorted_assert.svh */
// ----------------------------------------------------------------------------
// max_priority_queue_sorted_assert.svh
// Assertion macros for the sorted max-priority queue.
// ----------------------------------------------------------------------------
`ifndef MAX_PRIORITY_QUEUE_SORTED_ASSERT_SVH
`define MAX_PRIORITY_QUEUE_SORTED_ASSERT_SVH

`ifndef SYNTH

`define MPQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MPQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MPQS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define MPQS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* design/mpqs_pkg.sv */
// ----------------------------------------------------------------------------
// mpqs_pkg
// Constants, codes and types shared by the sorted max-priority queue.
// ----------------------------------------------------------------------------
package mpqs_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2,
        REQ_RSVD = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

endpackage

/* design/mpqs_if.sv */
// ----------------------------------------------------------------------------
// mpqs_if
// Request and result channels of the sorted max-priority queue.
// ----------------------------------------------------------------------------
interface mpqs_req_if;
    logic                                valid;
    logic                                ready;
    logic        [1:0]                   req_type;
    logic signed [mpqs_pkg::DATA_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mpqs_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [mpqs_pkg::DATA_W-1:0]  top_value;
    logic                                top_valid;
    logic        [4:0]                   entry_count;
    logic        [1:0]                   status;

    modport source (output valid, output top_value, output top_valid,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input top_value, input top_valid,
                    input entry_count, input status, output ready);
endinterface

/* design/mpqs_ram.sv */
// ----------------------------------------------------------------------------
// mpqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* design/max_priority_queue_sorted.sv */
// ----------------------------------------------------------------------------
// max_priority_queue_sorted
// Bounded max-priority queue held in ascending order in a RAM.
// ----------------------------------------------------------------------------
// Takes one request at a time (push, pop or peek) and answers each with the
// largest stored value, a valid flag, the entry count and a status. A push
// walks down from the top through the RAM, one read and one compare per
// cycle, shifting larger entries up by one. A pop that leaves entries reads
// the new top from the RAM. The request channel is ready again once the
// result is in the output register.
// ----------------------------------------------------------------------------
`include "max_priority_queue_sorted_assert.svh"

module max_priority_queue_sorted (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mpqs_req_if.sink         i_req,
    mpqs_rsp_if.source       o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PLACE,
        S_POPRD,
        S_DONE
    } t_state;

    t_state                                r_state, n_state;
    logic        [mpqs_pkg::CNT_W-1:0]     r_count, n_count;
    logic        [mpqs_pkg::CNT_W-1:0]     r_pos, n_pos;
    logic signed [mpqs_pkg::DATA_W-1:0]    r_val, n_val;
    logic signed [mpqs_pkg::DATA_W-1:0]    r_top, n_top;
    mpqs_pkg::t_status                     r_status, n_status;

    logic                                  r_out_valid;
    logic signed [mpqs_pkg::DATA_W-1:0]    r_out_top;
    logic                                  r_out_top_valid;
    logic        [4:0]                     r_out_count;
    mpqs_pkg::t_status                     r_out_status;

    logic                                  w_we;
    logic        [mpqs_pkg::ADDR_W-1:0]    w_waddr;
    logic        [mpqs_pkg::DATA_W-1:0]    w_wdata;
    logic        [mpqs_pkg::ADDR_W-1:0]    w_raddr;
    logic        [mpqs_pkg::DATA_W-1:0]    w_rdata;
    logic                                  w_req_acc;
    logic                                  w_out_free;
    logic                                  w_greater;
    mpqs_pkg::t_req                        w_req_type;

    mpqs_ram #(
        .WIDTH (mpqs_pkg::DATA_W),
        .DEPTH (mpqs_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_greater   = $signed(w_rdata) > r_val;
    assign w_req_type  = mpqs_pkg::t_req'(i_req.req_type);

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.top_value   = r_out_top;
    assign o_rsp.top_valid   = r_out_top_valid;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.status      = r_out_status;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_pos    = r_pos;
        n_val    = r_val;
        n_top    = r_top;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_pos[mpqs_pkg::ADDR_W-1:0];
        w_wdata  = r_val;
        w_raddr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    n_status = mpqs_pkg::ST_OK;
                    n_state  = S_DONE;
                    unique case (w_req_type)
                        mpqs_pkg::REQ_PUSH: begin
                            n_val = i_req.value;
                            n_pos = r_count;
                            if (r_count >= mpqs_pkg::CNT_W'(mpqs_pkg::CAPACITY)) begin
                                n_status = mpqs_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = i_req.value;
                                n_top   = i_req.value;
                                n_count = r_count + 1'b1;
                            end else begin
                                w_raddr = mpqs_pkg::ADDR_W'(r_count - 1'b1);
                                n_state = S_CMP;
                            end
                        end
                        mpqs_pkg::REQ_POP: begin
                            if (r_count == '0) begin
                                n_status = mpqs_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                                if (r_count == mpqs_pkg::CNT_W'(1)) begin
                                    n_top = '0;
                                end else begin
                                    w_raddr = mpqs_pkg::ADDR_W'(r_count - 2'd2);
                                    n_state = S_POPRD;
                                end
                            end
                        end
                        mpqs_pkg::REQ_PEEK,
                        mpqs_pkg::REQ_RSVD: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CMP: begin
                w_we = 1'b1;
                if (w_greater) begin
                    // shift the larger entry up one place
                    w_wdata = w_rdata;
                    n_pos   = r_pos - 1'b1;
                    if (r_pos == mpqs_pkg::CNT_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        w_raddr = mpqs_pkg::ADDR_W'(r_pos - 2'd2);
                    end
                end else begin
                    if (r_pos == r_count) begin
                        n_top = r_val;
                    end
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_POPRD: begin
                n_top   = $signed(w_rdata);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_val    <= n_val;
            r_top    <= n_top;
            r_status <= n_status;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid     <= 1'b1;
                r_out_top       <= (r_count == '0) ? '0 : r_top;
                r_out_top_valid <= (r_count != '0);
                r_out_count     <= 5'(r_count);
                r_out_status    <= r_status;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `MPQS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= mpqs_pkg::CNT_W'(mpqs_pkg::CAPACITY), "entry count above capacity")
    `MPQS_ASSERT_IMP(a_cmp_pos, i_clk, i_rst_n, r_state == S_CMP, r_pos != '0 && r_pos <= r_count, "compare position out of range")
    `MPQS_ASSERT_IMP(a_write_state, i_clk, i_rst_n, w_we, r_state == S_IDLE || r_state == S_CMP || r_state == S_PLACE, "store write outside a push")
    `MPQS_ASSERT_NXT(a_pop_count, i_clk, i_rst_n, w_req_acc && i_req.req_type == mpqs_pkg::REQ_POP && r_count != '0, r_count == $past(r_count) - 1'b1, "pop did not drop the count")
    `MPQS_ASSERT_NXT(a_done_load, i_clk, i_rst_n, r_state == S_DONE && w_out_free, r_out_valid && r_state == S_IDLE, "result not loaded on completion")

endmodule
